/* rtl/cft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_pkg: shared types, character codes and helpers of the CSV tokenizer
// Holds the item types of both channels, the command that travels from the
// front part to the back part, and the digit decoder of the numeric parser.
// ----------------------------------------------------------------------------
package cft_pkg;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Decimal text of a 32-bit magnitude has at most ten digits.
    localparam int MAX_DIGITS = 10;
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIGITS_W   = 4 * MAX_DIGITS;

    // Division by ten as multiply by reciprocal and shift.
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          QUOT_W      = 64 - DIV10_SHIFT;

    // Largest magnitude accepted while digits accumulate.
    localparam logic [35:0] ACC_LIMIT   = 36'h0_8000_0000;
    localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;

    // Character codes.
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_   = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    // Parse modes.
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_QUOTED = 2'd1;
    localparam logic [1:0] MODE_QQ     = 2'd2;

    // Numeric parser phases.
    localparam logic [2:0] PH_NONE   = 3'd0;
    localparam logic [2:0] PH_AMP    = 3'd1;
    localparam logic [2:0] PH_LEAD   = 3'd2;
    localparam logic [2:0] PH_SIGNED = 3'd3;
    localparam logic [2:0] PH_ZERO   = 3'd4;
    localparam logic [2:0] PH_XPREF  = 3'd5;
    localparam logic [2:0] PH_DIGITS = 3'd6;
    localparam logic [2:0] PH_STOP   = 3'd7;

    // Number bases.
    localparam logic [1:0] BASE_HEX = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_char;
    } t_in_item;

    typedef struct packed {
        logic       has_char;
        logic [7:0] out_char;
        logic       field_end;
        logic       line_end;
    } t_out_item;

    // One command per accepted beat at most: a ready result or a number.
    typedef struct packed {
        logic        is_num;
        logic        has_char;
        logic [7:0]  out_char;
        logic        field_end;
        logic        line_end;
        logic        minus;
        logic [31:0] mag;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // White space as the numeric reader skips it.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Digit value of a byte in the given base.
    function automatic t_digit digit_of(input logic [7:0] b, input logic [1:0] base);
        t_digit r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (b >= CH_0 && b <= CH_9) begin
            r.ok  = 1'b1;
            r.val = 4'(b - CH_0);
        end else if (b >= CH_LA && b <= CH_LF_) begin
            r.ok  = 1'b1;
            r.val = 4'(b - CH_LA + 8'd10);
        end else if (b >= CH_UA && b <= CH_UF) begin
            r.ok  = 1'b1;
            r.val = 4'(b - CH_UA + 8'd10);
        end
        if (base == BASE_OCT && r.val >= 4'd8) begin
            r.ok = 1'b0;
        end else if (base == BASE_BIN && r.val >= 4'd2) begin
            r.ok = 1'b0;
        end
        if (!r.ok) begin
            r.val = 4'd0;
        end
        return r;
    endfunction

endpackage

/* rtl/cft_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_stream_if: valid/ready channel
// Carries one payload beat when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface cft_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cft_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_front: byte classifier and field state
// Tracks quoting, the delayed field byte and the numeric reader, and turns
// each input beat into at most one command for the back part.
// ----------------------------------------------------------------------------
module cft_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cft_pkg::t_in_item i_item,
    output logic            o_ready,
    output logic            o_push,
    output cft_pkg::t_cmd   o_cmd,
    input  logic            i_full
);

    logic [1:0]  r_mode,        n_mode;
    logic        r_nonempty,    n_nonempty;
    logic        r_lead_chk,    n_lead_chk;
    logic [7:0]  r_held_byte,   n_held_byte;
    logic        r_held_valid,  n_held_valid;
    logic [2:0]  r_phase,       n_phase;
    logic [1:0]  r_base,        n_base;
    logic        r_neg,         n_neg;
    logic [31:0] r_value,       n_value;
    logic        r_failed,      n_failed;

    logic            accept;
    logic [7:0]      b;
    logic            delim;
    logic            do_push;
    logic [7:0]      push_val;
    logic            do_finish;
    logic            fin_le;
    logic            consumed;
    logic            num_ok;
    cft_pkg::t_digit dg;
    logic [35:0]     acc;
    logic            acc_over;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign b       = i_item.in_char;
    assign delim   = (b == cft_pkg::CH_COMMA) || (b == cft_pkg::CH_SEMI) ||
                     (b == cft_pkg::CH_BS);

    // Digit decode and accumulation for the byte pushed this beat.
    always_comb begin
        dg = cft_pkg::digit_of(push_val, r_base);
        unique case (r_base)
            cft_pkg::BASE_HEX: acc = {r_value, 4'd0} + 36'(dg.val);
            cft_pkg::BASE_OCT: acc = {1'b0, r_value, 3'd0} + 36'(dg.val);
            default:           acc = {3'd0, r_value, 1'b0} + 36'(dg.val);
        endcase
        acc_over = acc > cft_pkg::ACC_LIMIT;
    end

    // Next state and command for one beat.
    always_comb begin
        n_mode       = r_mode;
        n_nonempty   = r_nonempty;
        n_lead_chk   = r_lead_chk;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_phase      = r_phase;
        n_base       = r_base;
        n_neg        = r_neg;
        n_value      = r_value;
        n_failed     = r_failed;
        o_push       = 1'b0;
        o_cmd        = '0;
        do_push      = 1'b0;
        push_val     = b;
        do_finish    = 1'b0;
        fin_le       = 1'b0;
        consumed     = 1'b0;
        num_ok       = 1'b0;

        if (accept) begin
            // Classify the beat.
            if (i_item.req_type) begin
                n_mode = cft_pkg::MODE_PLAIN;
                if (r_nonempty) begin
                    do_finish = 1'b1;
                    fin_le    = 1'b1;
                end else begin
                    o_push         = 1'b1;
                    o_cmd.line_end = 1'b1;
                end
            end else begin
                unique case (r_mode)
                    cft_pkg::MODE_QUOTED: begin
                        if (b == cft_pkg::CH_QUOTE) begin
                            n_mode = cft_pkg::MODE_QQ;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                    cft_pkg::MODE_QQ: begin
                        if (b == cft_pkg::CH_QUOTE) begin
                            do_push  = 1'b1;
                            push_val = cft_pkg::CH_QUOTE;
                            n_mode   = cft_pkg::MODE_QUOTED;
                        end else begin
                            do_finish = delim;
                            n_mode    = cft_pkg::MODE_PLAIN;
                        end
                    end
                    default: begin
                        n_mode = cft_pkg::MODE_PLAIN;
                        if (b == cft_pkg::CH_QUOTE) begin
                            n_mode = cft_pkg::MODE_QUOTED;
                        end else if (delim) begin
                            do_finish = 1'b1;
                        end else if (!(b == cft_pkg::CH_SPACE && !r_nonempty)) begin
                            do_push = 1'b1;
                        end
                    end
                endcase
            end

            // Add one byte to the field.
            if (do_push) begin
                if (!r_nonempty) begin
                    n_nonempty = 1'b1;
                    consumed   = (push_val == cft_pkg::CH_QUOTE);
                end
                if (!consumed && !r_lead_chk) begin
                    n_lead_chk = 1'b1;
                    if (push_val == cft_pkg::CH_AMP) begin
                        n_phase  = cft_pkg::PH_AMP;
                        consumed = 1'b1;
                    end
                end
                if (!consumed) begin
                    if (r_phase == cft_pkg::PH_NONE) begin
                        // Text byte: release the held one, hold the new one.
                        if (r_held_valid) begin
                            o_push         = 1'b1;
                            o_cmd.has_char = 1'b1;
                            o_cmd.out_char = r_held_byte;
                        end
                        n_held_byte  = push_val;
                        n_held_valid = 1'b1;
                    end else begin
                        unique case (r_phase)
                            cft_pkg::PH_AMP: begin
                                n_phase = cft_pkg::PH_LEAD;
                                if (push_val == cft_pkg::CH_LH ||
                                    push_val == cft_pkg::CH_UH) begin
                                    n_base = cft_pkg::BASE_HEX;
                                end else if (push_val == cft_pkg::CH_LO ||
                                             push_val == cft_pkg::CH_UO) begin
                                    n_base = cft_pkg::BASE_OCT;
                                end else if (push_val == cft_pkg::CH_LB ||
                                             push_val == cft_pkg::CH_UB) begin
                                    n_base = cft_pkg::BASE_BIN;
                                end else begin
                                    n_failed = 1'b1;
                                    n_phase  = cft_pkg::PH_STOP;
                                end
                            end
                            cft_pkg::PH_LEAD, cft_pkg::PH_SIGNED: begin
                                if (r_phase == cft_pkg::PH_LEAD &&
                                    cft_pkg::is_ws(push_val)) begin
                                    n_phase = r_phase;
                                end else if (r_phase == cft_pkg::PH_LEAD &&
                                             (push_val == cft_pkg::CH_PLUS ||
                                              push_val == cft_pkg::CH_MINUS)) begin
                                    n_neg   = (push_val == cft_pkg::CH_MINUS);
                                    n_phase = cft_pkg::PH_SIGNED;
                                end else if (!dg.ok) begin
                                    n_failed = 1'b1;
                                    n_phase  = cft_pkg::PH_STOP;
                                end else begin
                                    if (acc_over) begin
                                        n_failed = 1'b1;
                                    end else begin
                                        n_value = acc[31:0];
                                    end
                                    n_phase = (r_base == cft_pkg::BASE_HEX &&
                                               dg.val == 4'd0) ?
                                              cft_pkg::PH_ZERO : cft_pkg::PH_DIGITS;
                                end
                            end
                            cft_pkg::PH_ZERO, cft_pkg::PH_XPREF,
                            cft_pkg::PH_DIGITS: begin
                                if (r_phase == cft_pkg::PH_ZERO &&
                                    (push_val == cft_pkg::CH_LX ||
                                     push_val == cft_pkg::CH_UX)) begin
                                    n_phase = cft_pkg::PH_XPREF;
                                end else if (!dg.ok) begin
                                    n_phase = cft_pkg::PH_STOP;
                                end else begin
                                    if (acc_over) begin
                                        n_failed = 1'b1;
                                    end else begin
                                        n_value = acc[31:0];
                                    end
                                    n_phase = cft_pkg::PH_DIGITS;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end

            // Close the field and clear its state.
            if (do_finish) begin
                o_push          = 1'b1;
                o_cmd.field_end = 1'b1;
                o_cmd.line_end  = fin_le;
                if (r_phase != cft_pkg::PH_NONE) begin
                    num_ok = !r_failed && r_phase != cft_pkg::PH_AMP &&
                             r_phase != cft_pkg::PH_LEAD &&
                             r_phase != cft_pkg::PH_SIGNED &&
                             !(!r_neg && r_value > cft_pkg::POS_MAX);
                    o_cmd.is_num = 1'b1;
                    o_cmd.mag    = num_ok ? r_value : 32'd0;
                    o_cmd.minus  = num_ok && r_neg && (r_value != 32'd0);
                end else if (r_held_valid && r_held_byte != cft_pkg::CH_QUOTE) begin
                    o_cmd.has_char = 1'b1;
                    o_cmd.out_char = r_held_byte;
                end
                n_nonempty   = 1'b0;
                n_lead_chk   = 1'b0;
                n_held_byte  = 8'd0;
                n_held_valid = 1'b0;
                n_phase      = cft_pkg::PH_NONE;
                n_base       = cft_pkg::BASE_HEX;
                n_neg        = 1'b0;
                n_value      = 32'd0;
                n_failed     = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= cft_pkg::MODE_PLAIN;
            r_nonempty   <= 1'b0;
            r_lead_chk   <= 1'b0;
            r_held_byte  <= 8'd0;
            r_held_valid <= 1'b0;
            r_phase      <= cft_pkg::PH_NONE;
            r_base       <= cft_pkg::BASE_HEX;
            r_neg        <= 1'b0;
            r_value      <= 32'd0;
            r_failed     <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_nonempty   <= n_nonempty;
            r_lead_chk   <= n_lead_chk;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_phase      <= n_phase;
            r_base       <= n_base;
            r_neg        <= n_neg;
            r_value      <= n_value;
            r_failed     <= n_failed;
        end
    end

endmodule

/* rtl/cft_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_fifo: command queue
// Short first-in first-out queue of commands between the front and back parts.
// ----------------------------------------------------------------------------
module cft_fifo #(
    parameter int DEPTH = cft_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cft_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output cft_pkg::t_cmd o_pop_cmd,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cft_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_mem[r_rd_ptr];
    assign wr_en     = i_push && !o_full;
    assign rd_en     = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/cft_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cft_back: result emitter
// Sends text results straight to the output register and turns numeric
// commands into decimal text, one digit per divide step.
// ----------------------------------------------------------------------------
module cft_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  cft_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output cft_pkg::t_out_item o_item,
    input  logic               i_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                     r_state,     n_state;
    cft_pkg::t_out_item             r_out,       n_out;
    logic                           r_out_valid, n_out_valid;
    logic [31:0]                    r_mag,       n_mag;
    logic [cft_pkg::QUOT_W-1:0]     r_q,         n_q;
    logic                           r_minus,     n_minus;
    logic                           r_le,        n_le;
    logic [cft_pkg::NDIG_W-1:0]     r_ndig,      n_ndig;
    logic [cft_pkg::DIGITS_W-1:0]   r_digits,    n_digits;

    logic        out_free;
    logic [63:0] prod;
    logic [31:0] rem;
    logic        last;

    assign o_valid  = r_out_valid;
    assign o_item   = r_out;
    assign out_free = !r_out_valid || i_ready;

    // Quotient by ten and the remainder that goes with it.
    assign prod = {32'd0, r_mag} * {32'd0, cft_pkg::DIV10_MAGIC};
    assign rem  = r_mag - ({r_q, 3'd0} + {2'd0, r_q, 1'd0});
    assign last = (r_ndig == cft_pkg::NDIG_W'(1));

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        n_mag       = r_mag;
        n_q         = r_q;
        n_minus     = r_minus;
        n_le        = r_le;
        n_ndig      = r_ndig;
        n_digits    = r_digits;
        o_pop       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_num) begin
                        n_mag    = i_cmd.mag;
                        n_minus  = i_cmd.minus;
                        n_le     = i_cmd.line_end;
                        n_ndig   = '0;
                        n_digits = '0;
                        n_state  = ST_DIV;
                    end else begin
                        n_out.has_char  = i_cmd.has_char;
                        n_out.out_char  = i_cmd.out_char;
                        n_out.field_end = i_cmd.field_end;
                        n_out.line_end  = i_cmd.line_end;
                        n_out_valid     = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                n_q     = prod[63:cft_pkg::DIV10_SHIFT];
                n_state = ST_REM;
            end
            ST_REM: begin
                // Newest digit enters at the bottom; the top digit ends there.
                n_digits = {r_digits[cft_pkg::DIGITS_W-5:0], rem[3:0]};
                n_ndig   = r_ndig + 1'b1;
                n_mag    = 32'(r_q);
                n_state  = (r_q == '0) ? ST_EMIT : ST_DIV;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_minus) begin
                        n_out.has_char  = 1'b1;
                        n_out.out_char  = cft_pkg::CH_MINUS;
                        n_out.field_end = 1'b0;
                        n_out.line_end  = 1'b0;
                        n_minus         = 1'b0;
                    end else begin
                        n_out.has_char  = 1'b1;
                        n_out.out_char  = cft_pkg::CH_0 + {4'd0, r_digits[3:0]};
                        n_out.field_end = last;
                        n_out.line_end  = r_le && last;
                        n_digits        = r_digits >> 4;
                        n_ndig          = r_ndig - 1'b1;
                        if (last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and conversion registers.
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_mag    <= n_mag;
        r_q      <= n_q;
        r_minus  <= n_minus;
        r_le     <= n_le;
        r_ndig   <= n_ndig;
        r_digits <= n_digits;
    end

endmodule

/* rtl/csv_field_tokenizer.sv */
`timescale 1ns / 1ps
// A text result goes from the front state into the command queue and then
// into the output register. Throughput: one input beat per cycle while the
// queue is not full; one text result per cycle while the output is ready.
// The back part divides a number by ten once per digit (divide, then
// remainder), sends sign and digits, and only then takes the next command.
// Reset is synchronous, active low: plain text, empty field, empty queue.
// ----------------------------------------------------------------------------
// csv_field_tokenizer: CSV line splitter with quoted and numeric fields
// Front part classifies bytes and keeps field state, a command queue
// decouples it from the back part, which sends field bytes and decimal text.
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
    parameter int QUEUE_DEPTH = cft_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cft_stream_if.sink          i_in,
    cft_stream_if.source        o_out
);

    logic               push;
    cft_pkg::t_cmd      push_cmd;
    logic               full;
    logic               pop;
    cft_pkg::t_cmd      pop_cmd;
    logic               empty;
    logic               front_ready;
    logic               out_valid;
    cft_pkg::t_out_item out_item;
    cft_pkg::t_in_item  in_item;

    assign in_item     = i_in.data;
    assign i_in.ready  = front_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;

    // Byte classifier and field state.
    cft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (front_ready),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    // Command queue.
    cft_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (empty)
    );

    // Result emitter.
    cft_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_valid (out_valid),
        .o_item  (out_item),
        .i_ready (o_out.ready)
    );

endmodule
